// ===== hw/rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the character table of the base64 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD  = 2'd2;
    localparam logic [1:0] IDX_LAST   = 2'd3;

    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_ONE,
        PAD_TWO
    } pad_t;

    typedef struct packed {
        logic [23:0] bits;
        pad_t        pad;
        logic        fin;
    } group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] s);
        logic [6:0] sx;
        sx = {1'b0, s};
        if (s < 6'd26)
        begin
            sextet_char = sx + 7'd65;
        end
        else if (s < 6'd52)
        begin
            sextet_char = sx + 7'd71;
        end
        else if (s < 6'd62)
        begin
            sextet_char = sx - 7'd4;
        end
        else if (s == 6'd62)
        begin
            sextet_char = 7'h2B;
        end
        else
        begin
            sextet_char = 7'h2F;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// accepts input bytes, keeps the pending bytes and hands out complete groups, or padded ones on a final byte
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             final_byte,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output b64e_pkg::group_t      push_group
);

    logic [15:0] pend_bytes_reg;
    logic [15:0] pend_bytes_next;
    logic [1:0]  pend_cnt_reg;
    logic [1:0]  pend_cnt_next;
    logic        accept;
    logic        emits;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        emits           = (pend_cnt_reg == 2'd2) || final_byte;
        push_group.bits = {in_byte, 16'h0000};
        push_group.pad  = b64e_pkg::PAD_TWO;
        push_group.fin  = final_byte;
        priority if (pend_cnt_reg == 2'd2)
        begin
            push_group.bits = {pend_bytes_reg, in_byte};
            push_group.pad  = b64e_pkg::PAD_NONE;
        end
        else if (final_byte && pend_cnt_reg == 2'd1)
        begin
            push_group.bits = {pend_bytes_reg[7:0], in_byte, 8'h00};
            push_group.pad  = b64e_pkg::PAD_ONE;
        end
        else
        begin
            push_group.bits = {in_byte, 16'h0000};
            push_group.pad  = b64e_pkg::PAD_TWO;
        end
        push_valid = in_valid && emits;

        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (accept)
        begin
            if (emits)
            begin
                pend_bytes_next = 16'h0000;
                pend_cnt_next   = 2'd0;
            end
            else
            begin
                pend_bytes_next = {pend_bytes_reg[7:0], in_byte};
                pend_cnt_next   = (pend_cnt_reg == 2'd3) ? 2'd1 : pend_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bytes_reg <= 16'h0000;
            pend_cnt_reg   <= 2'd0;
        end
        else
        begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
        end
    end

    // at most two bytes ever wait for their group
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("pending count out of range");

    // a final byte always leaves the front empty
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> pend_cnt_reg == 2'd0)
        else $error("pending bytes kept after final byte");

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// short group queue between the byte front and the character back
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire b64e_pkg::group_t push_group,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output b64e_pkg::group_t      pop_group
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    b64e_pkg::group_t mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_group  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill level stays within the storage
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// turns queued groups into four characters in an output register, one per cycle while the receiver takes them
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire b64e_pkg::group_t pop_group,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [6:0]            out_char,
    output logic                  group_end,
    output logic                  text_end
);

    b64e_pkg::group_t cur_reg;
    b64e_pkg::group_t cur_next;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [6:0]       out_char_reg;
    logic [6:0]       out_char_next;
    logic             group_end_reg;
    logic             group_end_next;
    logic             text_end_reg;
    logic             text_end_next;
    logic             step;
    logic             last;
    logic [5:0]       sextet;
    logic             is_pad;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign group_end = group_end_reg;
    assign text_end  = text_end_reg;

    always_comb
    begin
        step      = cur_valid_reg && (!out_valid_reg || out_ready);
        last      = (idx_reg == b64e_pkg::IDX_LAST);
        pop_ready = !cur_valid_reg || (step && last);

        unique case (idx_reg)
            b64e_pkg::IDX_FIRST:  sextet = cur_reg.bits[23:18];
            b64e_pkg::IDX_SECOND: sextet = cur_reg.bits[17:12];
            b64e_pkg::IDX_THIRD:  sextet = cur_reg.bits[11:6];
            default:              sextet = cur_reg.bits[5:0];
        endcase
        is_pad = (last && cur_reg.pad != b64e_pkg::PAD_NONE)
              || (idx_reg == b64e_pkg::IDX_THIRD && cur_reg.pad == b64e_pkg::PAD_TWO);

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        group_end_next = group_end_reg;
        text_end_next  = text_end_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            out_char_next  = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
            group_end_next = last;
            text_end_next  = last && cur_reg.fin;
            idx_next       = idx_reg + 2'd1;
            if (last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop_valid && pop_ready)
        begin
            cur_next       = pop_group;
            cur_valid_next = 1'b1;
            idx_next       = b64e_pkg::IDX_FIRST;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_char_reg  <= out_char_next;
        group_end_reg <= group_end_next;
        text_end_reg  <= text_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= b64e_pkg::IDX_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // end of text only ever marks the last character of a group
    a_text_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && text_end_reg |-> group_end_reg)
        else $error("text end without group end");

    // a group in progress is not dropped before its last character
    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last |=> cur_valid_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("group left before last character");

endmodule

`default_nettype wire

// ===== hw/rtl/base64_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// input channel: one data byte per word (in_byte) with final_byte on the
// last byte of a message; an empty message sends no words
// output channel: one character per word (out_char); group_end marks the
// last character of each four-character group, text_end the last of the message
// every third byte, or a final byte, yields four characters; other bytes
// yield none and are held in the front
// the byte that completes a group passes through the queue entry, the back's
// group register and the output register before its first character is offered
// throughput: one character per cycle from the single output register;
// input words are taken every cycle while the group queue (QueueDepth
// entries) has room
// a stalled receiver holds the output register; the back then stops, the
// queue fills and in_ready drops only when the queue is full
// reset clears the pending bytes, the queue and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder #(
    parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       final_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      out_char,
    output logic            group_end,
    output logic            text_end
);

    logic             push_valid;
    logic             push_ready;
    b64e_pkg::group_t push_group;
    logic             pop_valid;
    logic             pop_ready;
    b64e_pkg::group_t pop_group;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group)
    );

    b64e_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_group (pop_group),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .group_end (group_end),
        .text_end  (text_end)
    );

endmodule

`default_nettype wire
